// ===== src/tbpc_pkg.sv =====
// Package for the timed blind position controller.
// Holds the state, configuration and motion types, command codes and the motion helper.
`timescale 1ns / 1ps

package tbpc_pkg;

  localparam int unsigned PeriodW = 16;
  localparam int unsigned PosW    = 7;
  localparam int unsigned AngW    = 8;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PosW-1:0]        POS_MAX   = 7'd100;
  localparam logic [PosW-1:0]        POS_MIN   = 7'd0;
  localparam logic signed [AngW-1:0] ANGLE_MAX = 8'sd90;
  localparam logic signed [AngW-1:0] ANGLE_MIN = -8'sd90;

  localparam logic [PeriodW-1:0] PCT_PERIOD_RST = 16'd300;
  localparam logic [PeriodW-1:0] ANG_PERIOD_RST = 16'd10;

  typedef enum logic [1:0] {
    MOT_STOPPED = 2'd0,
    MOT_OPENING = 2'd1,
    MOT_CLOSING = 2'd2
  } motion_t;

  typedef enum logic [FuncW-1:0] {
    FN_TICK    = 3'd0,
    FN_OPEN    = 3'd1,
    FN_CLOSE   = 3'd2,
    FN_STOP    = 3'd3,
    FN_GOTO_PC = 3'd4,
    FN_GOTO_AN = 3'd5
  } func_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PCT_PERIOD = 2'd0,
    REG_ANG_PERIOD = 2'd1,
    REG_ANG_ENABLE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [PeriodW-1:0] pct_period;
    logic [PeriodW-1:0] ang_period;
    logic               ang_enable;
  } cfg_t;

  typedef struct packed {
    motion_t                motion;
    logic [PosW-1:0]        position;
    logic signed [AngW-1:0] angle;
    logic                   pos_goal_vld;
    logic [PosW-1:0]        pos_goal;
    logic                   ang_goal_vld;
    logic signed [AngW-1:0] ang_goal;
    logic                   ang_running;
    logic [PeriodW-1:0]     pct_presc;
    logic [PeriodW-1:0]     ang_presc;
  } blind_state_t;

  function automatic blind_state_t set_motion(blind_state_t s, motion_t m, logic ang_en);
    blind_state_t r;
    r              = s;
    r.pos_goal_vld = 1'b0;
    r.ang_goal_vld = 1'b0;
    r.motion       = m;
    r.pct_presc    = '0;
    r.ang_presc    = '0;
    r.ang_running  = (m != MOT_STOPPED) && ang_en;
    return r;
  endfunction

endpackage

// ===== src/tbpc_step.sv =====
// Next-state logic of the blind controller for one command or tick.
// Depends on tbpc_pkg.
`timescale 1ns / 1ps

module tbpc_step import tbpc_pkg::*; (
  input  blind_state_t           cur,
  input  cfg_t                   cfg,
  input  logic [FuncW-1:0]       func,
  input  logic [PosW-1:0]        target_position,
  input  logic signed [AngW-1:0] target_slat_angle,
  output blind_state_t           nxt
);

  blind_state_t s;
  logic         pct_hit;
  logic         ang_hit;

  always_comb begin
    s       = cur;
    pct_hit = ({1'b0, cur.pct_presc} + 17'd1) >= {1'b0, cfg.pct_period};
    ang_hit = 1'b0;
    case (func_t'(func))
      FN_TICK: begin
        if (s.motion != MOT_STOPPED) begin
          if (pct_hit) begin
            s.pct_presc = '0;
            if (s.motion == MOT_CLOSING) begin
              if (s.position >= POS_MAX) begin
                s.position = POS_MAX;
                s = set_motion(s, MOT_STOPPED, cfg.ang_enable);
              end else begin
                s.position = PosW'(s.position + 7'd1);
              end
            end else begin
              if (s.position == POS_MIN) begin
                s = set_motion(s, MOT_STOPPED, cfg.ang_enable);
              end else begin
                s.position = PosW'(s.position - 7'd1);
              end
            end
            if (s.pos_goal_vld && (s.pos_goal == s.position)) begin
              s = set_motion(s, MOT_STOPPED, cfg.ang_enable);
            end
          end else begin
            s.pct_presc = PeriodW'(s.pct_presc + 16'd1);
          end
          if ((s.motion != MOT_STOPPED) && s.ang_running && cfg.ang_enable) begin
            ang_hit = ({1'b0, s.ang_presc} + 17'd1) >= {1'b0, cfg.ang_period};
            if (ang_hit) begin
              s.ang_presc = '0;
              if (s.motion == MOT_CLOSING) begin
                if (s.angle < ANGLE_MAX) begin
                  s.angle = AngW'(s.angle + 8'sd1);
                end else begin
                  s.angle       = ANGLE_MAX;
                  s.ang_running = 1'b0;
                end
              end else begin
                if (s.angle > ANGLE_MIN) begin
                  s.angle = AngW'(s.angle - 8'sd1);
                end else begin
                  s.angle       = ANGLE_MIN;
                  s.ang_running = 1'b0;
                end
              end
              if (s.ang_goal_vld && (s.ang_goal == s.angle)) begin
                s = set_motion(s, MOT_STOPPED, cfg.ang_enable);
              end
            end else begin
              s.ang_presc = PeriodW'(s.ang_presc + 16'd1);
            end
          end
        end
      end
      FN_OPEN:  s = set_motion(s, MOT_OPENING, cfg.ang_enable);
      FN_CLOSE: s = set_motion(s, MOT_CLOSING, cfg.ang_enable);
      FN_STOP:  s = set_motion(s, MOT_STOPPED, cfg.ang_enable);
      FN_GOTO_PC: begin
        if (target_position > s.position) begin
          s              = set_motion(s, MOT_CLOSING, cfg.ang_enable);
          s.pos_goal     = target_position;
          s.pos_goal_vld = 1'b1;
        end else if (target_position < s.position) begin
          s              = set_motion(s, MOT_OPENING, cfg.ang_enable);
          s.pos_goal     = target_position;
          s.pos_goal_vld = 1'b1;
        end
      end
      FN_GOTO_AN: begin
        if (cfg.ang_enable) begin
          if (target_slat_angle > s.angle) begin
            s              = set_motion(s, MOT_CLOSING, cfg.ang_enable);
            s.ang_goal     = target_slat_angle;
            s.ang_goal_vld = 1'b1;
          end else if (target_slat_angle < s.angle) begin
            s              = set_motion(s, MOT_OPENING, cfg.ang_enable);
            s.ang_goal     = target_slat_angle;
            s.ang_goal_vld = 1'b1;
          end
        end
      end
      default: ;
    endcase
    nxt = s;
  end

endmodule

// ===== src/timed_blind_position_controller.sv =====
// Top level of the timed blind position controller: handshakes, config and state registers.
// Depends on tbpc_pkg and tbpc_step.
//
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid / in_stall | func, target_position, target_slat_angle
//   out_    | output    | out_valid/out_stall | motion_state, position_percent, slat_angle,
//           |           |                     | open_relay, close_relay
//   cfg_    | input     | cfg_wr_en           | cfg_index, cfg_wdata
//
// One item per cycle sustained while the result is not stalled.
// The item passes an input register, then the step logic updates state and the result register.
// Synchronous active-low reset sets the state, config and valid flags, not the data registers.
// A stalled result holds; the input register still fills, and in_stall rises only when both
// the input and result registers are full.
`timescale 1ns / 1ps

module timed_blind_position_controller import tbpc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FuncW-1:0]       in_func,
  input  logic [PosW-1:0]        in_target_position,
  input  logic signed [AngW-1:0] in_target_slat_angle,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_motion_state,
  output logic [PosW-1:0]        out_position_percent,
  output logic signed [AngW-1:0] out_slat_angle,
  output logic                   out_open_relay,
  output logic                   out_close_relay,
  input  logic                   cfg_wr_en,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [PeriodW-1:0]     cfg_wdata
);

  cfg_t                   cfg_r;
  blind_state_t           st_r;
  blind_state_t           st_nxt;
  logic                   in_vld_r;
  logic [FuncW-1:0]       func_r;
  logic [PosW-1:0]        tpos_r;
  logic signed [AngW-1:0] tang_r;
  logic                   out_vld_r;
  motion_t                out_mot_r;
  logic [PosW-1:0]        out_pos_r;
  logic signed [AngW-1:0] out_ang_r;
  logic                   adv;
  logic                   in_xfer;

  assign adv      = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  tbpc_step u_step (
    .cur               (st_r),
    .cfg               (cfg_r),
    .func              (func_r),
    .target_position   (tpos_r),
    .target_slat_angle (tang_r),
    .nxt               (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pct_period <= PCT_PERIOD_RST;
      cfg_r.ang_period <= ANG_PERIOD_RST;
      cfg_r.ang_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PCT_PERIOD: cfg_r.pct_period <= cfg_wdata;
        REG_ANG_PERIOD: cfg_r.ang_period <= cfg_wdata;
        REG_ANG_ENABLE: cfg_r.ang_enable <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      st_r      <= '{motion: MOT_STOPPED, default: '0};
    end else begin
      if (in_xfer) begin
        in_vld_r <= 1'b1;
      end else if (adv) begin
        in_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= in_vld_r;
        if (in_vld_r) begin
          st_r <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= in_func;
      tpos_r <= in_target_position;
      tang_r <= in_target_slat_angle;
    end
    if (adv && in_vld_r) begin
      out_mot_r <= st_nxt.motion;
      out_pos_r <= st_nxt.position;
      out_ang_r <= st_nxt.angle;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_motion_state     = out_mot_r;
  assign out_position_percent = out_pos_r;
  assign out_slat_angle       = out_ang_r;
  assign out_open_relay       = (out_mot_r == MOT_OPENING);
  assign out_close_relay      = (out_mot_r == MOT_CLOSING);

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.position <= POS_MAX)
    else $error("position beyond travel limit");

  a_ang_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.angle <= ANGLE_MAX) && (st_r.angle >= ANGLE_MIN))
    else $error("slat angle beyond limit");

  a_stop_no_angle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.motion == MOT_STOPPED) |-> !st_r.ang_running)
    else $error("angle stepping while stopped");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_vld_r && adv) |=> $stable(st_r))
    else $error("state changed without a transfer");

  a_result_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && adv) |=> (out_valid && out_mot_r == st_r.motion
                           && out_pos_r == st_r.position && out_ang_r == st_r.angle))
    else $error("result differs from state");

endmodule
